>>> hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked out of reset only.
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Property checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
    localparam int QUO_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int SUM_W  = QUO_W + CNT_W - 1;
    localparam int STEP_W = $clog2(QUO_W);

    localparam int THR_W      = 8;
    localparam int SIZE_W     = 12;
    localparam int EFF_W      = QUO_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int CH_W       = 8;
    localparam int IN_DATA_W  = 3 * CH_W;
    localparam int OUT_PAY_W  = COL_W + ROW_W + CNT_W;
    localparam int OUT_DATA_W = ((OUT_PAY_W + 7) / 8) * 8;
    localparam int OUT_CY_LSB  = COL_W;
    localparam int OUT_CNT_LSB = COL_W + ROW_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } t_cfg_idx;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic div_step;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic frame_done;
        logic out_busy;
    } t_stat;

endpackage

`default_nettype wire

>>> hw/rtl/bpc_div.sv
`default_nettype none

// Restoring shift-subtract divider, one quotient bit per step.
// The quotient must fit in QUO_W bits (true for a mean position).
module bpc_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_load,
    input  wire logic                        i_step,
    input  wire logic [bpc_pkg::SUM_W-1:0]   i_dividend,
    input  wire logic [bpc_pkg::CNT_W-1:0]   i_divisor,
    output logic      [bpc_pkg::QUO_W-1:0]   o_quotient
);
    import bpc_pkg::*;

    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_den;
    logic [QUO_W-1:0] r_quo;
    logic             fits;

    assign fits = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_dividend;
            r_den <= {i_divisor, {(QUO_W-1){1'b0}}};
            r_quo <= '0;
        end else if (i_step) begin
            if (fits) begin
                r_rem <= r_rem - r_den;
            end
            r_quo <= {r_quo[QUO_W-2:0], fits};
            r_den <= r_den >> 1;
        end
    end

    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> hw/rtl/bpc_ctrl.sv
`default_nettype none

module bpc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire bpc_pkg::t_stat i_stat,
    output bpc_pkg::t_cmd       o_cmd
);
    import bpc_pkg::*;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIV,
        ST_LOAD
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                ST_ACCUM: begin
                    r_step <= '0;
                    if (i_stat.frame_done) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(QUO_W - 1)) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (!i_stat.out_busy) begin
                        r_state <= ST_ACCUM;
                    end
                end
                default: r_state <= ST_ACCUM;
            endcase
        end
    end

    assign o_cmd.in_ready = (r_state == ST_ACCUM);
    assign o_cmd.div_step = (r_state == ST_DIV);
    assign o_cmd.load_out = (r_state == ST_LOAD) && !i_stat.out_busy;

endmodule

`default_nettype wire

>>> hw/rtl/bpc_datapath.sv
`default_nettype none

module bpc_datapath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                             i_pix_valid,
    input  wire logic [bpc_pkg::CH_W-1:0]         i_red,
    input  wire logic [bpc_pkg::CH_W-1:0]         i_green,
    input  wire logic [bpc_pkg::CH_W-1:0]         i_blue,
    input  wire logic                             i_res_ready,
    output logic                                  o_res_valid,
    output logic      [bpc_pkg::COL_W-1:0]        o_centroid_x,
    output logic      [bpc_pkg::ROW_W-1:0]        o_centroid_y,
    output logic                                  o_found,
    output logic      [bpc_pkg::CNT_W-1:0]        o_bright_count,
    input  wire bpc_pkg::t_cmd                    i_cmd,
    output bpc_pkg::t_stat                        o_stat
);
    import bpc_pkg::*;

    // configuration
    logic [THR_W-1:0]  r_thr;
    logic [SIZE_W-1:0] r_fw;
    logic [SIZE_W-1:0] r_fh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_W'(240);
            r_fw  <= SIZE_W'(640);
            r_fh  <= SIZE_W'(480);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD: r_thr <= i_cfg_wdata[THR_W-1:0];
                CFG_WIDTH:     r_fw  <= i_cfg_wdata[SIZE_W-1:0];
                CFG_HEIGHT:    r_fh  <= i_cfg_wdata[SIZE_W-1:0];
                default:       ;
            endcase
        end
    end

    // effective frame size: zero acts as one, oversize clamps
    logic [EFF_W-1:0] w_eff;
    logic [EFF_W-1:0] h_eff;

    always_comb begin
        if (r_fw == '0) begin
            w_eff = EFF_W'(1);
        end else if ({1'b0, r_fw} > (SIZE_W+1)'(MAX_WIDTH)) begin
            w_eff = EFF_W'(MAX_WIDTH);
        end else begin
            w_eff = EFF_W'(r_fw);
        end
        if (r_fh == '0) begin
            h_eff = EFF_W'(1);
        end else if ({1'b0, r_fh} > (SIZE_W+1)'(MAX_HEIGHT)) begin
            h_eff = EFF_W'(MAX_HEIGHT);
        end else begin
            h_eff = EFF_W'(r_fh);
        end
    end

    // position, accumulators
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [SUM_W-1:0] r_col_sum;
    logic [SUM_W-1:0] r_row_sum;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] n_col_sum;
    logic [SUM_W-1:0] n_row_sum;
    logic [CNT_W-1:0] n_cnt;
    logic             accept;
    logic             bright;
    logic             row_end;
    logic             frame_end;

    assign accept = i_pix_valid && i_cmd.in_ready;
    assign bright = (i_red >= r_thr) && (i_green >= r_thr) && (i_blue >= r_thr);

    assign row_end   = (EFF_W'(r_col) + EFF_W'(1)) >= w_eff;
    assign frame_end = row_end && ((EFF_W'(r_row) + EFF_W'(1)) >= h_eff);

    assign n_col_sum = bright ? r_col_sum + SUM_W'(r_col) : r_col_sum;
    assign n_row_sum = bright ? r_row_sum + SUM_W'(r_row) : r_row_sum;
    assign n_cnt     = bright ? r_cnt + 1'b1 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_col_sum <= '0;
            r_row_sum <= '0;
            r_cnt     <= '0;
        end else if (accept) begin
            if (!row_end) begin
                r_col <= r_col + 1'b1;
            end else begin
                r_col <= '0;
                r_row <= frame_end ? '0 : r_row + 1'b1;
            end
            if (frame_end) begin
                r_col_sum <= '0;
                r_row_sum <= '0;
                r_cnt     <= '0;
            end else begin
                r_col_sum <= n_col_sum;
                r_row_sum <= n_row_sum;
                r_cnt     <= n_cnt;
            end
        end
    end

    // frame snapshot and dividers
    logic             div_load;
    logic [CNT_W-1:0] r_snap_cnt;
    logic [QUO_W-1:0] quo_x;
    logic [QUO_W-1:0] quo_y;

    assign div_load = accept && frame_end;

    always_ff @(posedge i_clk) begin
        if (div_load) begin
            r_snap_cnt <= n_cnt;
        end
    end

    bpc_div u_div_x (
        .i_clk      (i_clk),
        .i_load     (div_load),
        .i_step     (i_cmd.div_step),
        .i_dividend (n_col_sum),
        .i_divisor  (n_cnt),
        .o_quotient (quo_x)
    );

    bpc_div u_div_y (
        .i_clk      (i_clk),
        .i_load     (div_load),
        .i_step     (i_cmd.div_step),
        .i_dividend (n_row_sum),
        .i_divisor  (n_cnt),
        .o_quotient (quo_y)
    );

    // result register; last centroid is kept for empty frames
    logic [COL_W-1:0] r_last_x;
    logic [ROW_W-1:0] r_last_y;
    logic             r_out_valid;
    logic [COL_W-1:0] r_out_x;
    logic [ROW_W-1:0] r_out_y;
    logic             r_out_found;
    logic [CNT_W-1:0] r_out_cnt;
    logic             snap_found;

    assign snap_found = (r_snap_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                if (snap_found) begin
                    r_last_x <= quo_x[COL_W-1:0];
                    r_last_y <= quo_y[ROW_W-1:0];
                end
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_x     <= snap_found ? quo_x[COL_W-1:0] : r_last_x;
            r_out_y     <= snap_found ? quo_y[ROW_W-1:0] : r_last_y;
            r_out_found <= snap_found;
            r_out_cnt   <= r_snap_cnt;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_centroid_x   = r_out_x;
    assign o_centroid_y   = r_out_y;
    assign o_found        = r_out_found;
    assign o_bright_count = r_out_cnt;

    assign o_stat.frame_done = div_load;
    assign o_stat.out_busy   = r_out_valid && !i_res_ready;

endmodule

`default_nettype wire

>>> hw/rtl/bright_pixel_centroid.sv
// Bright-pixel centroid of a raster-order RGB pixel stream.
//
// Slave stream: one pixel per transfer, red/green/blue in s_axis_tdata.
// Column and row counters place each pixel inside a frame of
// frame_width x frame_height (zero acts as one, sizes clamp at 2048).
// A pixel is bright when all three channels reach bright_threshold.
// Master stream: one transfer per frame, sent after the frame's last
// pixel: truncated mean column and row of the bright pixels (previous
// centroid when none), bright pixel count in tdata, found flag in tuser.
// Throughput: one pixel per cycle inside a frame. After the last pixel
// of a frame, s_axis_tready drops while two shift-subtract dividers
// produce one quotient bit per cycle (11 steps) and the result register
// is loaded; m_axis_tvalid rises with that load.
// The result register sits between the sides: pixels of the next frame
// are taken while it waits. If the previous result is still untaken when
// the next one is ready, input stays stalled until the receiver drains it.
// Reset (i_rst_n low, synchronous) restores the register defaults
// (threshold 240, 640 x 480), clears counters, sums and the last centroid,
// and drops m_axis_tvalid. Write config only while the block is idle.
`default_nettype none

module bright_pixel_centroid (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // pixel stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    input  wire logic [bpc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [10:0] centroid_x, [21:11] centroid_y, [44:22] bright_count, zero pad
    output logic      [bpc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] found
    output logic                                   m_axis_tuser
);
    import bpc_pkg::*;

    t_cmd             cmd;
    t_stat            stat;
    logic [COL_W-1:0] cx;
    logic [ROW_W-1:0] cy;
    logic [CNT_W-1:0] cnt;

    bpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bpc_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_pix_valid    (s_axis_tvalid),
        .i_red          (s_axis_tdata[CH_W-1:0]),
        .i_green        (s_axis_tdata[2*CH_W-1:CH_W]),
        .i_blue         (s_axis_tdata[3*CH_W-1:2*CH_W]),
        .i_res_ready    (m_axis_tready),
        .o_res_valid    (m_axis_tvalid),
        .o_centroid_x   (cx),
        .o_centroid_y   (cy),
        .o_found        (m_axis_tuser),
        .o_bright_count (cnt),
        .i_cmd          (cmd),
        .o_stat         (stat)
    );

    assign s_axis_tready = cmd.in_ready;
    assign m_axis_tdata  = {{(OUT_DATA_W-OUT_PAY_W){1'b0}}, cnt, cy, cx};

endmodule

`default_nettype wire

>>> hw/rtl/bpc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module bpc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [bpc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                           m_axis_tuser
);
    import bpc_pkg::*;

    logic             pix_xfer;
    logic [CNT_W-1:0] out_cnt;

    assign pix_xfer = s_axis_tvalid && s_axis_tready;
    assign out_cnt  = m_axis_tdata[OUT_CNT_LSB+CNT_W-1:OUT_CNT_LSB];

    // stalled result holds
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    // found flag agrees with count
    `ASSERT_RST(a_found_cnt, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tuser == (out_cnt != '0)))
    // a new result is loaded only while the input side is stalled
    `ASSERT_RST(a_no_early, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    // after reset: result dropped and no pixel taken, or input side ready
    `ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !m_axis_tvalid && !pix_xfer || s_axis_tready)

endmodule

bind bright_pixel_centroid bpc_checker u_bpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
